[hw/rtl/sliding_window_anagram_finder_assert.svh]
// assertion helpers for the anagram finder
`ifndef SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

`define SWAF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("swaf assertion failed");

`define SWAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("swaf assertion failed");

`else

`define SWAF_ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define SWAF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/swaf_pkg.sv]
`default_nettype none

package swaf_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int WINDOW_MAX    = 256;
    localparam int INDEX_BITS    = 32;

    localparam int ACTION_BITS = 2;
    localparam int SYM_BITS    = 8;
    localparam int START_BITS  = 32;

    localparam int ALPHA_BITS = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SLOT_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int CNT_BITS   = $clog2(ALPHABET_SIZE + 1);
    localparam int BAL_BITS   = LEN_BITS + 1;
    localparam int DIFF_BITS  = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
    localparam int WIDE_BITS  = (DIFF_BITS > START_BITS) ? DIFF_BITS : START_BITS;

    localparam logic [SYM_BITS:0] SYM_LIMIT = (SYM_BITS + 1)'(ALPHABET_SIZE);
    localparam logic [LEN_BITS:0] WIN_LIMIT = (LEN_BITS + 1)'(WINDOW_MAX);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_SCAN  = 2'd2
    } swaf_action_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic load_step;
        logic in_step;
        logic out_step;
    } swaf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic out_valid;
    } swaf_status_t;

endpackage

`default_nettype wire

[hw/rtl/swaf_ram.sv]
`default_nettype none

module swaf_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/swaf_ctrl.sv]
`default_nettype none
`include "sliding_window_anagram_finder_assert.svh"

module swaf_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [swaf_pkg::ACTION_BITS-1:0]  s_action,
    input  wire swaf_pkg::swaf_status_t            status,
    output swaf_pkg::swaf_cmd_t                    cmd
);

    import swaf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_IN   = 4'b0100,
        S_OUT  = 4'b1000
    } swaf_state_t;

    swaf_state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    unique case (s_action)
                        ACT_CLEAR: cmd.clear  = 1'b1;
                        ACT_LOAD:  state_next = S_LOAD;
                        ACT_SCAN:  state_next = S_IN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd.load_step = 1'b1;
                state_next    = S_IDLE;
            end
            S_IN: begin
                cmd.in_step = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_step = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SWAF_ASSERT_NEXT(a_scan_enters_in, aclk, aresetn, s_valid && s_ready && s_action == ACT_SCAN, state_reg == S_IN)
    `SWAF_ASSERT_NEXT(a_in_then_out, aclk, aresetn, state_reg == S_IN, state_reg == S_OUT)
    `SWAF_ASSERT_NEXT(a_out_waits, aclk, aresetn, state_reg == S_OUT && !status.out_free, state_reg == S_OUT && status.out_valid)

endmodule

`default_nettype wire

[hw/rtl/swaf_dp.sv]
`default_nettype none
`include "sliding_window_anagram_finder_assert.svh"

module swaf_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [swaf_pkg::SYM_BITS-1:0]    s_symbol,
    input  wire swaf_pkg::swaf_cmd_t              cmd,
    output swaf_pkg::swaf_status_t                status,
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output logic                                  m_is_match,
    output logic [swaf_pkg::START_BITS-1:0]       m_window_start,
    output logic                                  m_pattern_overflow
);

    import swaf_pkg::*;

    logic [SYM_BITS-1:0]      sym_reg, old_reg, old_next;
    logic                     fwd_reg, fwd_next;
    logic [BAL_BITS-1:0]      fwd_val_reg, fwd_val_next;
    logic [ALPHABET_SIZE-1:0] inpat_reg, inpat_next;
    logic [CNT_BITS-1:0]      distinct_reg, distinct_next;
    logic [CNT_BITS-1:0]      sat_reg, sat_next;
    logic [LEN_BITS-1:0]      plen_reg, plen_next;
    logic [LEN_BITS-1:0]      fill_reg, fill_next;
    logic [SLOT_BITS-1:0]     slot_reg, slot_next;
    logic [INDEX_BITS-1:0]    pos_reg, pos_next;
    logic                     ovf_reg, ovf_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     match_reg;
    logic [START_BITS-1:0]    start_reg;
    logic                     movf_reg;

    logic                     bal_we;
    logic [ALPHA_BITS-1:0]    bal_waddr, bal_raddr;
    logic [BAL_BITS-1:0]      bal_wdata, bal_rdata;
    logic [SYM_BITS-1:0]      win_rdata;
    logic [SLOT_BITS-1:0]     win_raddr;
    logic [LEN_BITS:0]        slot_sum;

    logic                     sym_ok, in_hit, old_ok, old_hit, full;
    logic [ALPHA_BITS-1:0]    sym_idx, old_idx;
    logic [SYM_BITS-1:0]      old_byte;
    logic [BAL_BITS-1:0]      bal_cur, bal_dec, bal_out;
    logic [DIFF_BITS-1:0]     pos_wide, back_wide;
    logic [WIDE_BITS-1:0]     start_wide;
    logic                     match_now;

    // outgoing slot: write slot minus (pattern length - 1), modulo window size
    always_comb begin
        slot_sum = (LEN_BITS + 1)'(slot_reg) + WIN_LIMIT - (LEN_BITS + 1)'(plen_reg)
                   + (LEN_BITS + 1)'(1);
        if (slot_sum >= WIN_LIMIT) begin
            slot_sum = slot_sum - WIN_LIMIT;
        end
        win_raddr = slot_sum[SLOT_BITS-1:0];
    end

    assign sym_ok  = ({1'b0, sym_reg} < SYM_LIMIT);
    assign sym_idx = sym_reg[ALPHA_BITS-1:0];
    assign in_hit  = sym_ok && inpat_reg[sym_idx];
    assign bal_cur = inpat_reg[sym_idx] ? bal_rdata : '0;
    assign bal_dec = bal_rdata - BAL_BITS'(1);

    assign old_byte = (plen_reg == LEN_BITS'(1)) ? sym_reg : win_rdata;
    assign old_ok   = ({1'b0, old_reg} < SYM_LIMIT);
    assign old_idx  = old_reg[ALPHA_BITS-1:0];
    assign old_hit  = old_ok && inpat_reg[old_idx];
    assign bal_out  = fwd_reg ? fwd_val_reg : bal_rdata;

    assign full = (plen_reg != '0) && (fill_reg >= plen_reg);

    assign pos_wide  = DIFF_BITS'(pos_reg);
    assign back_wide = DIFF_BITS'(plen_reg) - DIFF_BITS'(1);
    assign start_wide = (full && pos_wide >= back_wide) ?
                        WIDE_BITS'(pos_wide - back_wide) : '0;
    assign match_now = !ovf_reg && (plen_reg != '0) && (sat_reg == distinct_reg);

    always_comb begin
        if (cmd.capture) begin
            bal_raddr = s_symbol[ALPHA_BITS-1:0];
        end else if (cmd.in_step) begin
            bal_raddr = old_byte[ALPHA_BITS-1:0];
        end else begin
            bal_raddr = old_idx;
        end
    end

    always_comb begin
        inpat_next    = inpat_reg;
        distinct_next = distinct_reg;
        sat_next      = sat_reg;
        plen_next     = plen_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        old_next      = old_reg;
        fwd_next      = fwd_reg;
        fwd_val_next  = fwd_val_reg;
        bal_we        = 1'b0;
        bal_waddr     = sym_idx;
        bal_wdata     = bal_dec;

        if (cmd.clear) begin
            inpat_next    = '0;
            distinct_next = '0;
            sat_next      = '0;
            plen_next     = '0;
            fill_next     = '0;
            slot_next     = '0;
            pos_next      = '0;
            ovf_next      = 1'b0;
        end

        if (cmd.load_step) begin
            if (ovf_reg || ({1'b0, plen_reg} >= WIN_LIMIT)) begin
                ovf_next = 1'b1;
            end else if (sym_ok) begin
                if (!inpat_reg[sym_idx]) begin
                    inpat_next[sym_idx] = 1'b1;
                    distinct_next       = distinct_reg + CNT_BITS'(1);
                end else if (bal_rdata == '0 && sat_reg != '0) begin
                    sat_next = sat_reg - CNT_BITS'(1);
                end
                bal_we    = 1'b1;
                bal_wdata = bal_cur + BAL_BITS'(1);
                plen_next = plen_reg + LEN_BITS'(1);
            end
        end

        if (cmd.in_step) begin
            if (in_hit) begin
                bal_we = 1'b1;
                if (bal_dec == '0) begin
                    sat_next = sat_reg + CNT_BITS'(1);
                end
            end
            if ({1'b0, fill_reg} < WIN_LIMIT) begin
                fill_next = fill_reg + LEN_BITS'(1);
            end
            slot_next    = (slot_reg == SLOT_BITS'(WINDOW_MAX - 1)) ?
                           '0 : slot_reg + SLOT_BITS'(1);
            old_next     = old_byte;
            fwd_next     = in_hit && (old_byte == sym_reg);
            fwd_val_next = bal_dec;
        end

        if (cmd.out_step) begin
            if (full && old_hit) begin
                if (bal_out == '0 && sat_reg != '0) begin
                    sat_next = sat_reg - CNT_BITS'(1);
                end
                bal_we    = 1'b1;
                bal_waddr = old_idx;
                bal_wdata = bal_out + BAL_BITS'(1);
            end
            if (pos_reg != '1) begin
                pos_next = pos_reg + INDEX_BITS'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inpat_reg    <= '0;
            distinct_reg <= '0;
            sat_reg      <= '0;
            plen_reg     <= '0;
            fill_reg     <= '0;
            slot_reg     <= '0;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            inpat_reg    <= inpat_next;
            distinct_reg <= distinct_next;
            sat_reg      <= sat_next;
            plen_reg     <= plen_next;
            fill_reg     <= fill_next;
            slot_reg     <= slot_next;
            pos_reg      <= pos_next;
            ovf_reg      <= ovf_next;
            fwd_reg      <= fwd_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg <= s_symbol;
        end
        old_reg     <= old_next;
        fwd_val_reg <= fwd_val_next;
        if (cmd.out_step) begin
            match_reg <= match_now;
            start_reg <= start_wide[START_BITS-1:0];
            movf_reg  <= ovf_reg;
        end
    end

    swaf_ram #(
        .WIDTH (BAL_BITS),
        .DEPTH (ALPHABET_SIZE)
    ) u_bal_ram (
        .clk     (aclk),
        .wr_en   (bal_we),
        .wr_addr (bal_waddr),
        .wr_data (bal_wdata),
        .rd_addr (bal_raddr),
        .rd_data (bal_rdata)
    );

    swaf_ram #(
        .WIDTH (SYM_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_win_ram (
        .clk     (aclk),
        .wr_en   (cmd.in_step),
        .wr_addr (slot_reg),
        .wr_data (sym_reg),
        .rd_addr (win_raddr),
        .rd_data (win_rdata)
    );

    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.out_valid = m_valid_reg;

    assign m_valid            = m_valid_reg;
    assign m_is_match         = match_reg;
    assign m_window_start     = start_reg;
    assign m_pattern_overflow = movf_reg;

    `SWAF_ASSERT_NEXT(a_result_loaded, aclk, aresetn, cmd.out_step, m_valid_reg)
    `SWAF_ASSERT_IMPLY(a_fill_bound, aclk, aresetn, 1'b1, {1'b0, fill_reg} <= WIN_LIMIT)
    `SWAF_ASSERT_IMPLY(a_plen_bound, aclk, aresetn, 1'b1, {1'b0, plen_reg} <= WIN_LIMIT)

endmodule

`default_nettype wire

[hw/rtl/sliding_window_anagram_finder.sv]
`default_nettype none

// Sliding-window anagram search. Each word carries an action: clear resets all
// counts, load adds one pattern byte, and scan pushes one text byte and returns
// one result word (match flag, start index of the window ending at that byte,
// pattern overflow flag). m_valid rises once the scan has passed the S_IN and
// S_OUT states, and s_ready returns with it; a scan stays in S_OUT while an
// earlier result still waits for m_ready. The scan time is set by the single
// balance table memory, which needs a read-modify-write for the incoming byte
// and then another for the byte leaving the window.
// The table needs no clearing pass: a per-symbol pattern bit, cleared at once,
// marks which table entries hold live counts.
module sliding_window_anagram_finder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [swaf_pkg::ACTION_BITS-1:0]   s_action,
    input  wire logic [swaf_pkg::SYM_BITS-1:0]      s_symbol,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_is_match,
    output logic [swaf_pkg::START_BITS-1:0]         m_window_start,
    output logic                                    m_pattern_overflow
);

    import swaf_pkg::*;

    swaf_cmd_t    cmd;
    swaf_status_t status;

    swaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    swaf_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_symbol           (s_symbol),
        .cmd                (cmd),
        .status             (status),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_is_match         (m_is_match),
        .m_window_start     (m_window_start),
        .m_pattern_overflow (m_pattern_overflow)
    );

endmodule

`default_nettype wire
